### hdl/http_chunked_body_decoder_core_macros.svh
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HCBD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chunked body decoder check failed");

// Next-cycle implication, disabled during reset.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chunked body decoder check failed");

`endif

### hdl/hcbd_pkg.sv
// Package with constants, types and helper functions of the chunked body decoder.
`default_nettype none

package hcbd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int SizeWide  = (SIZE_BITS > 32) ? SIZE_BITS : 32;

   localparam logic [3:0] PH_START     = 4'd0;
   localparam logic [3:0] PH_SIZE      = 4'd1;
   localparam logic [3:0] PH_EXT       = 4'd2;
   localparam logic [3:0] PH_CR1       = 4'd3;
   localparam logic [3:0] PH_LINE_DONE = 4'd4;
   localparam logic [3:0] PH_DATA      = 4'd5;
   localparam logic [3:0] PH_CR2       = 4'd6;
   localparam logic [3:0] PH_TRAILER   = 4'd7;
   localparam logic [3:0] PH_TRL_CR    = 4'd8;
   localparam logic [3:0] PH_TRL_LF    = 4'd9;
   localparam logic [3:0] PH_CR3       = 4'd10;

   localparam logic [1:0] OUT_MORE  = 2'd0;
   localparam logic [1:0] OUT_CHUNK = 2'd1;
   localparam logic [1:0] OUT_BODY  = 2'd2;
   localparam logic [1:0] OUT_BAD   = 2'd3;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [3:0] HEX_TEN   = 4'd10;

   typedef struct packed {
      logic [3:0]           phase;
      logic [SIZE_BITS-1:0] size;
      logic [SIZE_BITS-1:0] count;
   } state_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [31:0] current_size;
      logic        final_chunk;
   } result_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.hit   = 1'b1;
      h.value = 4'd0;
      priority if (c >= CH_ZERO && c <= CH_NINE) begin
         h.value = 4'(c - CH_ZERO);
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         h.value = 4'(c - CH_LOW_A) + HEX_TEN;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         h.value = 4'(c - CH_UP_A) + HEX_TEN;
      end else begin
         h.hit = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [31:0] low_word(input logic [SIZE_BITS-1:0] size);
      logic [SizeWide-1:0] w;
      w = SizeWide'(size);
      return w[31:0];
   endfunction

endpackage

`default_nettype wire

### hdl/http_chunked_body_decoder_core.sv
// Chunked HTTP body decoder: one body byte per request, one result per byte, up to one a cycle.
// Each request carries one raw byte of a chunked body and yields exactly one response with
// the parse outcome (need more, chunk complete, body complete, bad), the byte passed through
// when it is chunk payload, and the chunk size parsed so far. A byte is captured in an input
// register, goes through one step of the parser against the held state when it advances,
// and lands in the response register, so a byte can be taken every cycle while the response
// side is not stalled.
// The response register lets a new request in while a finished response still waits.
`default_nettype none

`include "http_chunked_body_decoder_core_macros.svh"

module http_chunked_body_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_outcome,
   output logic             rsp_data_valid,
   output logic [7:0]       rsp_data_byte,
   output logic [31:0]      rsp_current_size,
   output logic             rsp_final_chunk
);

   logic                 in_vld_ff;
   logic                 in_vld_in;
   logic [7:0]           in_byte_ff;
   logic [7:0]           in_byte_in;
   hcbd_pkg::state_type  st_ff;
   hcbd_pkg::state_type  st_in;
   hcbd_pkg::state_type  st_step;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   hcbd_pkg::result_type out_res_ff;
   hcbd_pkg::result_type out_res_in;
   hcbd_pkg::result_type res_step;
   logic                 advance;
   logic                 take;

   hcbd_step u_step (
      .state_cur (st_ff),
      .byte_cur  (in_byte_ff),
      .state_nxt (st_step),
      .result    (res_step)
   );

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_vld_in  = take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      in_byte_in = take ? req_byte_in : in_byte_ff;
      st_in      = advance ? st_step : st_ff;
      out_vld_in = advance ? 1'b1 : ((out_vld_ff && rsp_ready) ? 1'b0 : out_vld_ff);
      out_res_in = advance ? res_step : out_res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         st_ff.phase <= hcbd_pkg::PH_START;
         st_ff.size  <= '0;
         st_ff.count <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         st_ff      <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_outcome      = out_res_ff.outcome;
   assign rsp_data_valid   = out_res_ff.data_valid;
   assign rsp_data_byte    = out_res_ff.data_byte;
   assign rsp_current_size = out_res_ff.current_size;
   assign rsp_final_chunk  = out_res_ff.final_chunk;

   `HCBD_ASSERT_IMPLY(a_data_is_more, clock, reset, rsp_valid && rsp_data_valid, rsp_outcome == hcbd_pkg::OUT_MORE)
   `HCBD_ASSERT_IMPLY(a_chunk_nonzero, clock, reset, rsp_valid && (rsp_outcome == hcbd_pkg::OUT_CHUNK), !rsp_final_chunk)
   `HCBD_ASSERT_IMPLY(a_count_bound, clock, reset, st_ff.phase == hcbd_pkg::PH_DATA, st_ff.count <= st_ff.size)
   `HCBD_ASSERT_NEXT(a_body_restart, clock, reset, advance && (res_step.outcome == hcbd_pkg::OUT_BODY), st_ff.phase == hcbd_pkg::PH_START)

endmodule

`default_nettype wire

### hdl/hcbd_step.sv
// Per-byte parse step: next parser state and result for one body byte.
`default_nettype none

module hcbd_step (
   input  wire hcbd_pkg::state_type  state_cur,
   input  wire logic [7:0]           byte_cur,
   output hcbd_pkg::state_type       state_nxt,
   output hcbd_pkg::result_type      result
);

   hcbd_pkg::hex_type digit;
   logic [1:0]        outcome;
   logic              valid;

   assign digit = hcbd_pkg::hex_decode(byte_cur);

   always_comb begin
      state_nxt = state_cur;
      outcome   = hcbd_pkg::OUT_MORE;
      valid     = 1'b0;
      unique case (state_cur.phase)
         hcbd_pkg::PH_START: begin
            if (digit.hit) begin
               state_nxt.size  = hcbd_pkg::SIZE_BITS'(digit.value);
               state_nxt.count = '0;
               state_nxt.phase = hcbd_pkg::PH_SIZE;
            end else begin
               outcome = hcbd_pkg::OUT_BAD;
            end
         end
         hcbd_pkg::PH_SIZE: begin
            if (digit.hit) begin
               if (state_cur.size[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                  outcome = hcbd_pkg::OUT_BAD;
               end else begin
                  state_nxt.size = {state_cur.size[hcbd_pkg::SIZE_BITS-5:0], digit.value};
               end
            end else if (byte_cur == hcbd_pkg::CH_CR) begin
               state_nxt.phase = hcbd_pkg::PH_CR1;
            end else begin
               state_nxt.phase = hcbd_pkg::PH_EXT;
            end
         end
         hcbd_pkg::PH_EXT: begin
            if (byte_cur == hcbd_pkg::CH_CR) begin
               state_nxt.phase = hcbd_pkg::PH_CR1;
            end
         end
         hcbd_pkg::PH_CR1: begin
            if (byte_cur == hcbd_pkg::CH_LF) begin
               state_nxt.phase = hcbd_pkg::PH_LINE_DONE;
            end else begin
               outcome = hcbd_pkg::OUT_BAD;
            end
         end
         hcbd_pkg::PH_LINE_DONE: begin
            if (state_cur.size == '0) begin
               state_nxt.phase = (byte_cur == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_CR3
                                                                : hcbd_pkg::PH_TRAILER;
            end else begin
               valid           = 1'b1;
               state_nxt.count = hcbd_pkg::SIZE_BITS'(1);
               state_nxt.phase = hcbd_pkg::PH_DATA;
            end
         end
         hcbd_pkg::PH_DATA: begin
            if (state_cur.count < state_cur.size) begin
               valid           = 1'b1;
               state_nxt.count = state_cur.count + hcbd_pkg::SIZE_BITS'(1);
            end else if (byte_cur == hcbd_pkg::CH_CR) begin
               state_nxt.phase = hcbd_pkg::PH_CR2;
            end else begin
               outcome = hcbd_pkg::OUT_BAD;
            end
         end
         hcbd_pkg::PH_CR2: begin
            if (byte_cur == hcbd_pkg::CH_LF) begin
               outcome         = hcbd_pkg::OUT_CHUNK;
               state_nxt.count = '0;
               state_nxt.phase = hcbd_pkg::PH_START;
            end else begin
               outcome = hcbd_pkg::OUT_BAD;
            end
         end
         hcbd_pkg::PH_TRAILER: begin
            if (byte_cur == hcbd_pkg::CH_CR) begin
               state_nxt.phase = hcbd_pkg::PH_TRL_CR;
            end
         end
         hcbd_pkg::PH_TRL_CR: begin
            if (byte_cur == hcbd_pkg::CH_LF) begin
               state_nxt.phase = hcbd_pkg::PH_TRL_LF;
            end else begin
               outcome = hcbd_pkg::OUT_BAD;
            end
         end
         hcbd_pkg::PH_TRL_LF: begin
            state_nxt.phase = (byte_cur == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_CR3
                                                             : hcbd_pkg::PH_TRAILER;
         end
         hcbd_pkg::PH_CR3: begin
            if (byte_cur == hcbd_pkg::CH_LF) begin
               outcome         = hcbd_pkg::OUT_BODY;
               state_nxt.count = '0;
               state_nxt.phase = hcbd_pkg::PH_START;
            end else begin
               outcome = hcbd_pkg::OUT_BAD;
            end
         end
         default: begin
            outcome         = hcbd_pkg::OUT_BAD;
            state_nxt.phase = hcbd_pkg::PH_START;
         end
      endcase
   end

   always_comb begin
      result.outcome      = outcome;
      result.data_valid   = valid;
      result.data_byte    = valid ? byte_cur : 8'd0;
      result.current_size = hcbd_pkg::low_word(state_nxt.size);
      result.final_chunk  = (state_nxt.size == '0);
   end

endmodule

`default_nettype wire
